### design/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// shared types, constants and saturation helper for the error diffusion dither
// ----------------------------------------------------------------------------
package edd_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int MAX_HEIGHT    = 4096;

    localparam int PIXEL_W  = 8;
    localparam int ERR_W    = 16;
    localparam int WIDE_W   = 20;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int IMG_W_W  = 7;
    localparam int IMG_H_W  = 13;
    localparam int ROW_W    = 12;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd64;

    // values in 1/16 units
    localparam logic signed [ERR_W-1:0]  THRESH = 16'sd2048;
    localparam logic signed [WIDE_W-1:0] WHITE  = 20'sd4080;

    typedef logic signed [ERR_W-1:0] err_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic row_end;
        logic last_row;
        logic frame_end;
    } pos_flags_t;

    typedef struct packed {
        logic out_bit;
        err_t right_share;
        err_t below_left_sum;
        err_t pend_left_next;
        err_t pend_below_next;
    } diff_result_t;

    function automatic err_t sat16(input logic signed [WIDE_W-1:0] v);
        err_t r;
        if (v > 20'sd32767)
        begin
            r = 16'sd32767;
        end
        else if (v < -20'sd32768)
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/edd_diffuse.sv
// ----------------------------------------------------------------------------
// edd_diffuse
// threshold and error split for one pixel, saturating fixed point
// ----------------------------------------------------------------------------
module edd_diffuse (
    input  logic [edd_pkg::PIXEL_W-1:0] pixel,
    input  edd_pkg::err_t               right_carry,
    input  edd_pkg::err_t               above,
    input  edd_pkg::err_t               pend_left,
    input  edd_pkg::err_t               pend_below,
    output edd_pkg::diff_result_t       result
);
    import edd_pkg::*;

    logic signed [WIDE_W-1:0] sum_w;
    err_t                     val;
    logic                     out_bit;
    logic signed [WIDE_W-1:0] err_w;
    logic signed [WIDE_W-1:0] e7;
    logic signed [WIDE_W-1:0] e3;
    logic signed [WIDE_W-1:0] e5;
    err_t                     s3;
    err_t                     s5;

    always_comb
    begin
        sum_w   = $signed({8'd0, pixel, 4'd0}) + WIDE_W'(right_carry) + WIDE_W'(above);
        val     = sat16(sum_w);
        out_bit = (val >= THRESH);
        err_w   = WIDE_W'(val) - (out_bit ? WHITE : 20'sd0);
        e7      = err_w * 20'sd7;
        e3      = err_w * 20'sd3;
        e5      = err_w * 20'sd5;
        s3      = sat16(e3 >>> 4);
        s5      = sat16(e5 >>> 4);

        result.out_bit         = out_bit;
        result.right_share     = sat16(e7 >>> 4);
        result.below_left_sum  = sat16(WIDE_W'(pend_left) + WIDE_W'(s3));
        result.pend_left_next  = sat16(WIDE_W'(pend_below) + WIDE_W'(s5));
        result.pend_below_next = sat16(err_w >>> 4);
    end

endmodule

### design/error_diffusion_dither_core.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_core
// 1-bit error diffusion of a gray raster stream, packed eight pixels a byte
//
//   channel  direction  signals
//   in       sink       in_valid, in_ready, pixel
//   out      source     out_valid, out_ready, packed_byte, frame_last
//   cfg      sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one pixel per cycle while the output is not stalled; a pixel passes the stage 1 and output registers
// stage 0 reads the below-error line memory, stage 1 adds, thresholds, writes back
// the right-carry loop through stage 1 sets the recurrence
// reset and each frame start need no clearing pass: row zero reads zero errors
// stage 1 holds only while the output register is full and not taken
// ----------------------------------------------------------------------------
module error_diffusion_dither_core #(
    parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [edd_pkg::PIXEL_W-1:0]   pixel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    packed_byte,
    output logic                          frame_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [edd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [edd_pkg::CFG_W-1:0]     cfg_data
);
    import edd_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW > IMG_W_W) ? CW : IMG_W_W;

    // configuration
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [IMG_W_W-1:0] w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [IMG_W_W-1:0] w_last;
    logic [ROW_W-1:0]   h_last;
    logic               cfg_fire;
    logic               cfg_clear;

    // stage 0 position
    logic [CW-1:0]      col_reg;
    logic [ROW_W-1:0]   row_reg;
    pos_flags_t         pos_in;
    logic               in_fire;

    // stage 1
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [CW-1:0]      s1_col_reg;
    pos_flags_t         s1_flags_reg;
    logic               s1_fire;

    // line memory and bypass
    err_t               line_mem [MAX_WIDTH];
    err_t               mem_q_reg;
    err_t               byp_reg;
    logic               use_mem_reg;
    err_t               last_col_reg;
    logic               mem_we;
    logic [CW-1:0]      mem_wr_addr;
    err_t               above;
    err_t               byp_next;
    logic               use_mem_next;

    // error state
    err_t               right_carry_reg;
    err_t               pend_left_reg;
    err_t               pend_below_reg;
    diff_result_t       diff;

    // packing and output
    logic [6:0]         pack_shift_reg;
    logic [2:0]         pack_fill_reg;
    logic [3:0]         fill_n;
    logic [7:0]         shift_n;
    logic               emit;
    logic               out_valid_reg;
    logic [7:0]         packed_byte_reg;
    logic               frame_last_reg;

    // configuration port
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_clear = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_clear = 1'b1;
                REG_IMAGE_HEIGHT: cfg_clear = 1'b1;
                default:          cfg_clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = IMG_W_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = IMG_W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = IMG_H_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = IMG_H_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
        w_last = w_eff - IMG_W_W'(1);
        h_last = ROW_W'(h_eff - IMG_H_W'(1));
    end

    // handshakes
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        pos_in.row_end   = (CMPW'(col_reg) == CMPW'(w_last));
        pos_in.last_row  = (row_reg == h_last);
        pos_in.frame_end = pos_in.row_end && pos_in.last_row;
    end

    // stage 0: position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_clear)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (pos_in.row_end)
            begin
                col_reg <= '0;
                row_reg <= pos_in.last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // stage 1 pipeline register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cfg_clear)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= pos_in;
        end
    end

    // write back of the below-left column
    always_comb
    begin
        mem_we      = s1_fire && !s1_flags_reg.last_row && (s1_col_reg != '0);
        mem_wr_addr = s1_col_reg - CW'(1);
    end

    // read source for the next pixel, with bypass of same-edge writes
    always_comb
    begin
        use_mem_next = 1'b0;
        byp_next     = '0;
        if (row_reg == '0)
        begin
            byp_next = '0;
        end
        else if (pos_in.row_end)
        begin
            if (s1_fire && s1_flags_reg.row_end && !s1_flags_reg.last_row)
            begin
                byp_next = diff.pend_left_next;
            end
            else
            begin
                byp_next = last_col_reg;
            end
        end
        else if (mem_we && (mem_wr_addr == col_reg))
        begin
            byp_next = diff.below_left_sum;
        end
        else
        begin
            use_mem_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_wr_addr] <= diff.below_left_sum;
        end
        if (in_fire)
        begin
            mem_q_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byp_reg     <= byp_next;
            use_mem_reg <= use_mem_next;
        end
        if (s1_fire && s1_flags_reg.row_end && !s1_flags_reg.last_row)
        begin
            last_col_reg <= diff.pend_left_next;
        end
    end

    assign above = use_mem_reg ? mem_q_reg : byp_reg;

    edd_diffuse u_diffuse (
        .pixel       (s1_pixel_reg),
        .right_carry (right_carry_reg),
        .above       (above),
        .pend_left   (pend_left_reg),
        .pend_below  (pend_below_reg),
        .result      (diff)
    );

    // error carries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_carry_reg <= '0;
            pend_left_reg   <= '0;
            pend_below_reg  <= '0;
        end
        else if (cfg_clear)
        begin
            right_carry_reg <= '0;
            pend_left_reg   <= '0;
            pend_below_reg  <= '0;
        end
        else if (s1_fire)
        begin
            right_carry_reg <= s1_flags_reg.row_end ? '0 : diff.right_share;
            if (s1_flags_reg.last_row || s1_flags_reg.row_end)
            begin
                pend_left_reg  <= '0;
                pend_below_reg <= '0;
            end
            else
            begin
                pend_left_reg  <= diff.pend_left_next;
                pend_below_reg <= diff.pend_below_next;
            end
        end
    end

    // bit packing
    always_comb
    begin
        fill_n  = {1'b0, pack_fill_reg} + 4'd1;
        shift_n = {pack_shift_reg, diff.out_bit};
        emit    = fill_n[3] || s1_flags_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_shift_reg <= '0;
            pack_fill_reg  <= '0;
        end
        else if (cfg_clear)
        begin
            pack_shift_reg <= '0;
            pack_fill_reg  <= '0;
        end
        else if (s1_fire)
        begin
            if (emit)
            begin
                pack_shift_reg <= '0;
                pack_fill_reg  <= '0;
            end
            else
            begin
                pack_shift_reg <= shift_n[6:0];
                pack_fill_reg  <= fill_n[2:0];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            packed_byte_reg <= shift_n << (4'd8 - fill_n);
            frame_last_reg  <= s1_flags_reg.frame_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packed_byte = packed_byte_reg;
    assign frame_last  = frame_last_reg;

`ifndef SYNTH
    a_frame_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_flags_reg.frame_end |=> out_valid_reg && frame_last_reg)
        else $error("frame end did not produce a last byte");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_flags_reg.frame_end |=> pack_fill_reg == '0 && right_carry_reg == '0)
        else $error("state not cleared after frame end");

    a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pos_in.row_end && !cfg_clear |=> col_reg == '0)
        else $error("column counter did not wrap at row end");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !s1_fire)
        else $error("stage 1 advanced into a full output register");
`endif

endmodule
